@@ rtl/core/arr_pkg.sv @@
// Shared types and constants for the address range registry.
// Used by arr_if, arr_cell and address_range_registry_core; no dependencies.
package arr_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int HANDLE_W    = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERLAP   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]   low;
        logic [ADDR_W-1:0]   high;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    // Probe broadcast to every cell; a lookup uses low == high == address.
    typedef struct packed {
        logic [ADDR_W-1:0]   low;
        logic [ADDR_W-1:0]   high;
        logic [HANDLE_W-1:0] handle;
    } t_probe;

    typedef struct packed {
        logic load;   // take the new entry
        logic shift;  // take the upper neighbor's entry
    } t_cell_ctl;

endpackage

@@ rtl/core/arr_if.sv @@
// Valid/ready channel interfaces for the address range registry.
// Depends on arr_pkg for field widths.
interface arr_in_if;
    logic                           valid;
    logic                           ready;
    logic [arr_pkg::CMD_W-1:0]      command;
    logic [arr_pkg::ADDR_W-1:0]     range_start;
    logic [arr_pkg::ADDR_W-1:0]     range_end;
    logic [arr_pkg::ADDR_W-1:0]     lookup_address;
    logic [arr_pkg::HANDLE_W-1:0]   entry_handle;

    modport source (output valid, command, range_start, range_end, lookup_address,
                    entry_handle, input ready);
    modport sink   (input valid, command, range_start, range_end, lookup_address,
                    entry_handle, output ready);
endinterface

interface arr_out_if;
    logic                           valid;
    logic                           ready;
    logic [arr_pkg::STATUS_W-1:0]   status;
    logic [arr_pkg::HANDLE_W-1:0]   found_handle;

    modport source (output valid, status, found_handle, input ready);
    modport sink   (input valid, status, found_handle, output ready);
endinterface

@@ rtl/core/arr_cell.sv @@
// One table slot: holds a range and its handle, compares against the probe.
// Depends on arr_pkg. Entries shift down toward slot zero on remove.
module arr_cell (
    input  logic               i_clk,
    input  arr_pkg::t_cell_ctl i_ctl,
    input  arr_pkg::t_entry    i_new,
    input  arr_pkg::t_entry    i_next,
    input  arr_pkg::t_probe    i_probe,
    output arr_pkg::t_entry    o_entry,
    output logic               o_rng_hit,
    output logic               o_hnd_hit
);

    arr_pkg::t_entry r_entry;
    logic            r_rng_hit;
    logic            r_hnd_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    // Inclusive overlap; a single address is the range [addr, addr].
    always_ff @(posedge i_clk) begin
        r_rng_hit <= (i_probe.high >= r_entry.low) && (i_probe.low <= r_entry.high);
        r_hnd_hit <= (i_probe.handle == r_entry.handle);
    end

    assign o_entry   = r_entry;
    assign o_rng_hit = r_rng_hit;
    assign o_hnd_hit = r_hnd_hit;

endmodule

@@ rtl/core/address_range_registry_core.sv @@
// Top level of the address range registry: command sequencer plus a chain of arr_cell.
// Depends on arr_pkg, arr_if (arr_in_if, arr_out_if) and arr_cell.
//
//  channel  | dir | payload                                              | transfer
//  ---------+-----+------------------------------------------------------+-------------------
//  i_cmd    | in  | command, range_start, range_end, lookup_address,     | valid && ready
//           |     | entry_handle                                         |
//  o_rsp    | out | status, found_handle                                 | valid && ready
//
// Each command passes a compare state (S_CMP), where all cells compare the probe and
// register their hits, and an update state (S_APPLY), where the first hit is picked and the
// table updated. A new command is taken in the update state when the output is free.
// The result sits in an output register; a stalled result holds the next update cycle.
// Synchronous active-low reset empties the table (count only) and clears all valids.
module address_range_registry_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    arr_in_if.sink     i_cmd,
    arr_out_if.source  o_rsp
);

    localparam int DEPTH = arr_pkg::TABLE_DEPTH;
    localparam int CNT_W = arr_pkg::CNT_W;

    arr_pkg::t_state  r_state, n_state;
    arr_pkg::t_cmd    r_cmd;
    arr_pkg::t_probe  r_probe;
    logic [CNT_W-1:0] r_count, n_count;

    logic                          r_out_valid;
    arr_pkg::t_status              r_status, n_status;
    logic [arr_pkg::HANDLE_W-1:0]  r_found, n_found;

    logic in_fire, out_free, apply_fire;
    logic do_load, do_shift;

    arr_pkg::t_entry    w_entry [DEPTH];
    arr_pkg::t_cell_ctl w_ctl   [DEPTH];
    logic [DEPTH-1:0]   w_rng_hit, w_hnd_hit, occ;
    logic [DEPTH-1:0]   rng_m, hnd_m, rng_first, hnd_first, shift_mask;
    logic [arr_pkg::HANDLE_W-1:0] sel_handle;

    arr_pkg::t_entry new_entry;

    // ---------------- handshake and sequencing ----------------
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = (r_state == arr_pkg::S_IDLE) ||
                         ((r_state == arr_pkg::S_APPLY) && out_free);
    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign apply_fire  = (r_state == arr_pkg::S_APPLY) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arr_pkg::S_IDLE: begin
                if (in_fire) n_state = arr_pkg::S_CMP;
            end
            arr_pkg::S_CMP: begin
                n_state = arr_pkg::S_APPLY;
            end
            arr_pkg::S_APPLY: begin
                if (out_free) n_state = in_fire ? arr_pkg::S_CMP : arr_pkg::S_IDLE;
            end
            default: n_state = arr_pkg::S_IDLE;
        endcase
    end

    // Capture the command; create ranges are normalized here.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd          <= arr_pkg::t_cmd'(i_cmd.command);
            r_probe.handle <= i_cmd.entry_handle;
            if (arr_pkg::t_cmd'(i_cmd.command) == arr_pkg::CMD_CREATE) begin
                if (i_cmd.range_start < i_cmd.range_end) begin
                    r_probe.low  <= i_cmd.range_start;
                    r_probe.high <= i_cmd.range_end;
                end else begin
                    r_probe.low  <= i_cmd.range_end;
                    r_probe.high <= i_cmd.range_start;
                end
            end else begin
                r_probe.low  <= i_cmd.lookup_address;
                r_probe.high <= i_cmd.lookup_address;
            end
        end
    end

    // ---------------- cell chain ----------------
    assign new_entry.low    = r_probe.low;
    assign new_entry.high   = r_probe.high;
    assign new_entry.handle = r_probe.handle;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign occ[g]         = (CNT_W'(g) < r_count);
        assign w_ctl[g].load  = do_load && (r_count == CNT_W'(g));
        assign w_ctl[g].shift = do_shift && shift_mask[g];

        if (g == DEPTH - 1) begin : g_last
            arr_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl[g]),
                .i_new    (new_entry),
                .i_next   (w_entry[g]),
                .i_probe  (r_probe),
                .o_entry  (w_entry[g]),
                .o_rng_hit(w_rng_hit[g]),
                .o_hnd_hit(w_hnd_hit[g])
            );
        end else begin : g_mid
            arr_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl[g]),
                .i_new    (new_entry),
                .i_next   (w_entry[g+1]),
                .i_probe  (r_probe),
                .o_entry  (w_entry[g]),
                .o_rng_hit(w_rng_hit[g]),
                .o_hnd_hit(w_hnd_hit[g])
            );
        end
    end

    // ---------------- first-hit selection ----------------
    assign rng_m      = w_rng_hit & occ;
    assign hnd_m      = w_hnd_hit & occ;
    assign rng_first  = rng_m & (~rng_m + DEPTH'(1));
    assign hnd_first  = hnd_m & (~hnd_m + DEPTH'(1));
    // Slots at and above the removed one take their upper neighbor.
    assign shift_mask = ~(hnd_first - DEPTH'(1));

    always_comb begin
        sel_handle = '0;
        for (int k = 0; k < DEPTH; k++) begin
            sel_handle = sel_handle | (w_entry[k].handle & {arr_pkg::HANDLE_W{rng_first[k]}});
        end
    end

    // ---------------- apply ----------------
    always_comb begin
        n_status = arr_pkg::ST_OK;
        n_found  = '0;
        n_count  = r_count;
        do_load  = 1'b0;
        do_shift = 1'b0;
        unique case (r_cmd)
            arr_pkg::CMD_CREATE: begin
                if (|rng_m) begin
                    n_status = arr_pkg::ST_OVERLAP;
                end else if (r_count == CNT_W'(DEPTH)) begin
                    n_status = arr_pkg::ST_FULL;
                end else begin
                    do_load = apply_fire;
                    n_count = r_count + CNT_W'(1);
                end
            end
            arr_pkg::CMD_LOOKUP: begin
                if (|rng_m) begin
                    n_found = sel_handle;
                end else begin
                    n_status = arr_pkg::ST_NOT_FOUND;
                end
            end
            arr_pkg::CMD_REMOVE: begin
                if (|hnd_m) begin
                    do_shift = apply_fire;
                    n_count  = r_count - CNT_W'(1);
                end else begin
                    n_status = arr_pkg::ST_NOT_FOUND;
                end
            end
            arr_pkg::CMD_NOP: begin
                n_status = arr_pkg::ST_OK;
            end
            default: n_status = arr_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (apply_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_fire) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.found_handle = r_found;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_count_on_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(r_state == arr_pkg::S_APPLY))
        else $error("entry count changed outside the update cycle");

    a_rsp_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == arr_pkg::S_APPLY))
        else $error("response raised without an update cycle");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == arr_pkg::ST_FULL)) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status pending while table not full");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_found != '0)) |-> (r_status == arr_pkg::ST_OK))
        else $error("nonzero handle with failing status");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for address_range_registry_core: directed and random create, lookup and remove
// traffic with random stalls on both channels, checked against an in-bench range table.
// Depends on arr_pkg and arr_if (arr_in_if, arr_out_if) from the RTL.
module tb;
    import arr_pkg::*;

    localparam int RAND_ITEMS  = 1050;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 10;
    localparam int HOLD_CYCLES = 200;
    localparam int PLAN        = 0;  // table as the generator expects it to evolve
    localparam int LIVE        = 1;  // table built from accepted transfers
    localparam int SEND        = 0;
    localparam int RECV        = 1;

    typedef struct packed {
        t_cmd                command;
        logic [ADDR_W-1:0]   range_start;
        logic [ADDR_W-1:0]   range_end;
        logic [ADDR_W-1:0]   lookup_address;
        logic [HANDLE_W-1:0] entry_handle;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] found_handle;
    } t_rsp;

    typedef struct packed {
        t_cmd command;
        t_rsp rsp;
    } t_due;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    arr_in_if  cmd_if ();
    arr_out_if rsp_if ();

    address_range_registry_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    t_entry      tbl [2][TABLE_DEPTH];
    int          fill [2];
    t_req        cmd_backlog [$];
    t_due        rsp_due [$];
    int unsigned burst_left [2];
    int unsigned send_wait;
    int unsigned rsp_wait;
    logic        cmd_taken = 1'b0;
    logic        rsp_taken = 1'b0;
    logic        rsp_hold  = 1'b0;
    int unsigned errors;
    int unsigned results_seen;
    int unsigned cycles;
    int unsigned tally [4][4];

    always #2 clk = ~clk;

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, rsp_due.size());
            $display("tb failed");
            $finish;
        end
    end

    // Range table behavior; which selects the planning copy or the live copy.
    function automatic t_rsp apply_command(int which, t_req r);
        t_rsp              res;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        int                hit;
        int                i;
        res.status       = ST_OK;
        res.found_handle = '0;
        hit              = -1;
        case (r.command)
            CMD_CREATE: begin
                lo = (r.range_start < r.range_end) ? r.range_start : r.range_end;
                hi = (r.range_start < r.range_end) ? r.range_end : r.range_start;
                for (i = 0; i < fill[which] && hit < 0; i++)
                    if (hi >= tbl[which][i].low && lo <= tbl[which][i].high) hit = i;
                // overlap wins over full
                if (hit >= 0) begin
                    res.status = ST_OVERLAP;
                end else if (fill[which] >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    tbl[which][fill[which]].low    = lo;
                    tbl[which][fill[which]].high   = hi;
                    tbl[which][fill[which]].handle = r.entry_handle;
                    fill[which]++;
                end
            end
            CMD_LOOKUP: begin
                for (i = 0; i < fill[which] && hit < 0; i++)
                    if (r.lookup_address >= tbl[which][i].low &&
                        r.lookup_address <= tbl[which][i].high) hit = i;
                if (hit >= 0) res.found_handle = tbl[which][hit].handle;
                else res.status = ST_NOT_FOUND;
            end
            CMD_REMOVE: begin
                for (i = 0; i < fill[which] && hit < 0; i++)
                    if (tbl[which][i].handle == r.entry_handle) hit = i;
                if (hit >= 0) begin
                    for (i = hit; i + 1 < fill[which]; i++) tbl[which][i] = tbl[which][i + 1];
                    fill[which]--;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_req mk_req(t_cmd c, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                                    logic [ADDR_W-1:0] addr, logic [HANDLE_W-1:0] h);
        t_req r;
        r.command        = c;
        r.range_start    = a;
        r.range_end      = b;
        r.lookup_address = addr;
        r.entry_handle   = h;
        return r;
    endfunction

    function automatic void queue_req(t_req r);
        t_rsp dummy;
        dummy = apply_command(PLAN, r);
        cmd_backlog = {cmd_backlog, r};
    endfunction

    // Mostly a random gap before the next transfer, with occasional runs of back-to-back transfers.
    function automatic int unsigned draw_gap(int side);
        if (burst_left[side] > 0) begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst_left[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // Sender
    always @(negedge clk) begin
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (send_wait > 0) begin
                send_wait--;
                cmd_if.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                t_req nxt;
                nxt = cmd_backlog.pop_front();
                cmd_if.command        <= nxt.command;
                cmd_if.range_start    <= nxt.range_start;
                cmd_if.range_end      <= nxt.range_end;
                cmd_if.lookup_address <= nxt.lookup_address;
                cmd_if.entry_handle   <= nxt.entry_handle;
                cmd_if.valid          <= 1'b1;
                send_wait = draw_gap(SEND);
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Command acceptance: predict the result at the transfer
    always @(posedge clk) begin : cmd_accept
        t_req got;
        t_due due;
        cmd_taken <= rst_n && cmd_if.valid && cmd_if.ready;
        if (rst_n && cmd_if.valid && cmd_if.ready) begin
            got.command        = t_cmd'(cmd_if.command);
            got.range_start    = cmd_if.range_start;
            got.range_end      = cmd_if.range_end;
            got.lookup_address = cmd_if.lookup_address;
            got.entry_handle   = cmd_if.entry_handle;
            due.command = got.command;
            due.rsp     = apply_command(LIVE, got);
            rsp_due = {rsp_due, due};
        end
    end

    // Receiver
    always @(negedge clk) begin
        if (rsp_taken) rsp_wait = draw_gap(RECV);
        if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
        end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Long receiver hold-off so the block backs up into its input channel
    initial begin
        wait (results_seen >= 200);
        @(negedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_hold <= 1'b0;
    end

    // Result checking
    always @(posedge clk) begin : rsp_check
        t_due want;
        rsp_taken <= rst_n && rsp_if.valid && rsp_if.ready;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (rsp_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d handle %h", $time,
                         rsp_if.status, rsp_if.found_handle);
            end else begin
                want = rsp_due.pop_front();
                tally[want.command][want.rsp.status]++;
                if (rsp_if.status !== want.rsp.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d actual %0d", $time,
                             want.rsp.status, rsp_if.status);
                end
                if (rsp_if.found_handle !== want.rsp.found_handle) begin
                    errors++;
                    $display("%0t: found_handle mismatch, expected %h actual %h", $time,
                             want.rsp.found_handle, rsp_if.found_handle);
                end
            end
        end
    end

    initial begin : stimulus
        t_req              r;
        t_entry            e;
        logic [ADDR_W-1:0] zone;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [63:0]       span;
        int                n;
        int                sel;
        cmd_if.valid          = 1'b0;
        cmd_if.command        = CMD_NOP;
        cmd_if.range_start    = '0;
        cmd_if.range_end      = '0;
        cmd_if.lookup_address = '0;
        cmd_if.entry_handle   = '0;
        rsp_if.ready          = 1'b0;

        // empty table, unused code
        queue_req(mk_req(CMD_LOOKUP, '0, '0, '0, '0));
        queue_req(mk_req(CMD_REMOVE, '0, '0, '0, '0));
        queue_req(mk_req(CMD_NOP, '1, '1, '1, '1));
        // bottom and top of the address space, handle zero, ends given high first
        queue_req(mk_req(CMD_CREATE, '0, '0, '1, '0));
        queue_req(mk_req(CMD_LOOKUP, '1, '1, '0, '1));
        queue_req(mk_req(CMD_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFF0, '0, 32'hFFFF_FFFF));
        queue_req(mk_req(CMD_LOOKUP, '0, '0, 32'hFFFF_FFFF, '0));
        queue_req(mk_req(CMD_CREATE, 32'h5, 32'hFFFF_FFF0, '0, 32'h1234_5678));
        // duplicate handles: remove takes the first only
        queue_req(mk_req(CMD_CREATE, 32'h1, 32'h10, '0, 32'hA5A5_A5A5));
        queue_req(mk_req(CMD_CREATE, 32'h30, 32'h20, '0, 32'hA5A5_A5A5));
        queue_req(mk_req(CMD_REMOVE, '0, '0, '0, 32'hA5A5_A5A5));
        queue_req(mk_req(CMD_LOOKUP, '0, '0, 32'h8, '0));
        queue_req(mk_req(CMD_LOOKUP, '0, '0, 32'h25, '0));
        // fill up, then full versus overlap
        for (n = 1; n <= 13; n++)
            queue_req(mk_req(CMD_CREATE, n << 12, (n << 12) + 32'hFF, '0, n));
        queue_req(mk_req(CMD_CREATE, 32'h8000_0000, 32'h8000_0010, '0, 32'h77));
        queue_req(mk_req(CMD_CREATE, 32'h1080, 32'h1080, '0, 32'h78));
        queue_req(mk_req(CMD_REMOVE, '0, '0, '0, 32'h7));
        queue_req(mk_req(CMD_LOOKUP, '0, '0, 32'h8010, '0));

        zone = '0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(0, 3))
                    0:       zone = '0;
                    1:       zone = 32'hFFFF_EF00;
                    default: zone = $urandom() & 32'hFFFF_0000;
                endcase
            end
            r = mk_req(CMD_NOP, $urandom(), $urandom(), $urandom(), $urandom());
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                r.command = CMD_NOP;
            end else if (sel < ((fill[PLAN] >= TABLE_DEPTH) ? 30 : 50)) begin
                r.command = CMD_CREATE;
                // mostly narrow ranges so the table fills and overlaps stay likely
                if ($urandom_range(0, 99) >= 15) begin
                    lo = ($urandom_range(0, 9) < 7) ? zone + $urandom_range(0, 4095) : $urandom();
                    hi = lo + $urandom_range(0, 255);
                    if (hi < lo) hi = '1;
                    if ($urandom_range(0, 1)) begin
                        r.range_start = lo;
                        r.range_end   = hi;
                    end else begin
                        r.range_start = hi;
                        r.range_end   = lo;
                    end
                end
                if ($urandom_range(0, 1)) r.entry_handle = $urandom_range(0, 7);
            end else if (sel < 78) begin
                r.command = CMD_LOOKUP;
                if (fill[PLAN] > 0 && $urandom_range(0, 2) != 0) begin
                    e = tbl[PLAN][$urandom_range(0, fill[PLAN] - 1)];
                    span = 64'(e.high) - 64'(e.low) + 64'd1;
                    r.lookup_address = e.low + 32'(64'($urandom()) % span);
                end else if ($urandom_range(0, 1)) begin
                    r.lookup_address = zone + $urandom_range(0, 4351);
                end
            end else begin
                r.command = CMD_REMOVE;
                if (fill[PLAN] > 0 && $urandom_range(0, 3) != 0)
                    r.entry_handle = tbl[PLAN][$urandom_range(0, fill[PLAN] - 1)].handle;
                else if ($urandom_range(0, 1))
                    r.entry_handle = $urandom_range(0, 7);
            end
            queue_req(r);
        end

        while (cmd_backlog.size() != 0 || cmd_if.valid || rsp_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d results: creates %0d stored, %0d overlapping, %0d refused as full",
                 results_seen, tally[CMD_CREATE][ST_OK], tally[CMD_CREATE][ST_OVERLAP],
                 tally[CMD_CREATE][ST_FULL]);
        $display("lookups %0d hit, %0d missed; removes %0d done, %0d missed; unused code %0d",
                 tally[CMD_LOOKUP][ST_OK], tally[CMD_LOOKUP][ST_NOT_FOUND],
                 tally[CMD_REMOVE][ST_OK], tally[CMD_REMOVE][ST_NOT_FOUND],
                 tally[CMD_NOP][ST_OK]);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/arr_pkg.sv
rtl/core/arr_if.sv
rtl/core/arr_cell.sv
rtl/core/address_range_registry_core.sv
dv/tb.sv
